[hdl/tfn_pkg.sv]
// Shared types and constants for the triangle face normal block.
`timescale 1ns / 1ps
package tfn_pkg;

    // Scaled magnitudes keep their top bit at bit MAG_BITS-1.
    localparam int MAG_BITS  = 30;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int LEN2_BITS = SQ_BITS + 2;
    localparam int ROOT_BITS = LEN2_BITS / 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR     = $clog2(Q_DEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hdl/tfn_front.sv]
// Front end: vertex differences, cross product and degenerate detection.
`timescale 1ns / 1ps
module tfn_front #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16,
    parameter int QW = 160
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [COORD_BITS-1:0] i_a_x,
    input  logic [COORD_BITS-1:0] i_a_y,
    input  logic [COORD_BITS-1:0] i_a_z,
    input  logic [COORD_BITS-1:0] i_b_x,
    input  logic [COORD_BITS-1:0] i_b_y,
    input  logic [COORD_BITS-1:0] i_b_z,
    input  logic [COORD_BITS-1:0] i_c_x,
    input  logic [COORD_BITS-1:0] i_c_y,
    input  logic [COORD_BITS-1:0] i_c_z,
    input  logic [INDEX_BITS-1:0] i_index_a,
    input  logic [INDEX_BITS-1:0] i_index_b,
    input  logic [INDEX_BITS-1:0] i_index_c,
    input  tfn_pkg::t_q_status    i_q_status,
    output logic                  o_q_push,
    output logic [QW-1:0]         o_q_data
);
    localparam int DW  = ((COORD_BITS > 31) ? 31 : COORD_BITS) + 1;
    localparam int PRE = (COORD_BITS > 31) ? COORD_BITS - 31 : 0;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;

    logic signed [COORD_BITS-1:0] w_a [3];
    logic signed [COORD_BITS-1:0] w_b [3];
    logic signed [COORD_BITS-1:0] w_c [3];
    logic signed [COORD_BITS:0]   w_uf [3];
    logic signed [COORD_BITS:0]   w_vf [3];
    logic signed [COORD_BITS:0]   w_us [3];
    logic signed [COORD_BITS:0]   w_vs [3];
    logic signed [CW-1:0]         w_cross [3];
    logic                         w_deg;
    logic                         w_adv;

    logic                         r_v1, r_v2;
    logic signed [DW-1:0]         r_u [3];
    logic signed [DW-1:0]         r_v [3];
    logic signed [PW-1:0]         r_p [6];
    logic [INDEX_BITS-1:0]        r_i1 [3];
    logic [INDEX_BITS-1:0]        r_i2 [3];

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;
    assign w_c[0] = i_c_x;
    assign w_c[1] = i_c_y;
    assign w_c[2] = i_c_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_uf[k] = $signed({w_b[k][COORD_BITS-1], w_b[k]})
                    - $signed({w_c[k][COORD_BITS-1], w_c[k]});
            w_vf[k] = $signed({w_b[k][COORD_BITS-1], w_b[k]})
                    - $signed({w_a[k][COORD_BITS-1], w_a[k]});
            w_us[k] = w_uf[k] >>> PRE;
            w_vs[k] = w_vf[k] >>> PRE;
        end
    end

    assign w_adv  = !(r_v2 && i_q_status.full);
    assign o_full = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= w_us[k][DW-1:0];
                r_v[k] <= w_vs[k][DW-1:0];
            end
            r_i1[0] <= i_index_a;
            r_i1[1] <= i_index_b;
            r_i1[2] <= i_index_c;
            r_p[0]  <= r_u[1] * r_v[2];
            r_p[1]  <= r_u[2] * r_v[1];
            r_p[2]  <= r_u[2] * r_v[0];
            r_p[3]  <= r_u[0] * r_v[2];
            r_p[4]  <= r_u[0] * r_v[1];
            r_p[5]  <= r_u[1] * r_v[0];
            r_i2    <= r_i1;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cross[k] = CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
        end
        w_deg = (w_cross[0] == '0) && (w_cross[1] == '0) && (w_cross[2] == '0);
    end

    assign o_q_push = r_v2 && !i_q_status.full;
    assign o_q_data = {w_deg, r_i2[2], r_i2[1], r_i2[0], w_cross[2], w_cross[1], w_cross[0]};

    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> r_v2)
        else $error("front stalled without a waiting item");
endmodule

[hdl/tfn_queue.sv]
// Short item queue between the front and back ends.
`timescale 1ns / 1ps
module tfn_queue #(
    parameter int W = 160
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [W-1:0]       i_data,
    input  logic               i_pop,
    output logic [W-1:0]       o_data,
    output tfn_pkg::t_q_status o_status
);
    logic [W-1:0]                r_mem [tfn_pkg::Q_DEPTH];
    logic [tfn_pkg::Q_PTR-1:0]   r_wp, r_rp;
    logic [tfn_pkg::Q_PTR:0]     r_cnt;

    assign o_status.full  = (r_cnt == (tfn_pkg::Q_PTR+1)'(tfn_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (tfn_pkg::Q_PTR+1)'(i_push) - (tfn_pkg::Q_PTR+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue read while empty");
endmodule

[hdl/tfn_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module tfn_sqrt #(
    parameter int SIDEW = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [tfn_pkg::LEN2_BITS-1:0]   i_n,
    input  logic [SIDEW-1:0]                i_side,
    output logic                            o_valid,
    output logic [tfn_pkg::ROOT_BITS-1:0]   o_root,
    output logic [SIDEW-1:0]                o_side
);
    localparam int NW = tfn_pkg::LEN2_BITS;
    localparam int RB = tfn_pkg::ROOT_BITS;
    localparam int RW = RB + 3;
    localparam int ST = RB;

    logic [NW-1:0]    r_n    [ST+1];
    logic [RW-1:0]    r_rem  [ST+1];
    logic [RB-1:0]    r_root [ST+1];
    logic [SIDEW-1:0] r_side [ST+1];
    logic             r_v    [ST+1];
    logic [RW-1:0]    w_rem2 [ST];
    logic [RW-1:0]    w_try  [ST];
    logic [NW-1:0]    n_n    [ST];
    logic [RW-1:0]    n_rem  [ST];
    logic [RB-1:0]    n_root [ST];

    always_comb begin
        for (int j = 0; j < ST; j++) begin
            w_rem2[j] = {r_rem[j][RW-3:0], r_n[j][NW-1:NW-2]};
            w_try[j]  = RW'({r_root[j], 2'b01});
            n_n[j]    = r_n[j] << 2;
            if (w_rem2[j] >= w_try[j]) begin
                n_rem[j]  = w_rem2[j] - w_try[j];
                n_root[j] = {r_root[j][RB-2:0], 1'b1};
            end else begin
                n_rem[j]  = w_rem2[j];
                n_root[j] = {r_root[j][RB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= ST; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < ST; j++) r_v[j+1] <= r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= i_n;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int j = 0; j < ST; j++) begin
                r_n[j+1]    <= n_n[j];
                r_rem[j+1]  <= n_rem[j];
                r_root[j+1] <= n_root[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_v[ST];
    assign o_root  = r_root[ST];
    assign o_side  = r_side[ST];
endmodule

[hdl/tfn_div.sv]
// Pipelined rounded division of three magnitudes by the length.
`timescale 1ns / 1ps
module tfn_div #(
    parameter int NORMAL_BITS = 16,
    parameter int SIDEW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [tfn_pkg::ROOT_BITS-1:0]     i_len,
    input  logic [3*tfn_pkg::MAG_BITS-1:0]    i_mag,
    input  logic [SIDEW-1:0]                  i_side,
    output logic                              o_valid,
    output logic [3*NORMAL_BITS-1:0]          o_quot,
    output logic [SIDEW-1:0]                  o_side
);
    localparam int NB   = NORMAL_BITS;
    localparam int MB   = tfn_pkg::MAG_BITS;
    localparam int LB   = tfn_pkg::ROOT_BITS;
    localparam int NUMW = MB + NB;

    logic [NUMW-1:0]  r_rem  [NB+1][3];
    logic [NB-1:0]    r_q    [NB+1][3];
    logic [LB-1:0]    r_len  [NB+1];
    logic [SIDEW-1:0] r_side [NB+1];
    logic             r_v    [NB+1];
    logic [NUMW-1:0]  w_d    [NB];
    logic [NUMW-1:0]  n_rem  [NB][3];
    logic [NB-1:0]    n_q    [NB][3];

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            w_d[j] = NUMW'(r_len[j]) << (NB - 1 - j);
            for (int k = 0; k < 3; k++) begin
                n_rem[j][k] = r_rem[j][k];
                n_q[j][k]   = r_q[j][k];
                if (r_rem[j][k] >= w_d[j]) begin
                    n_rem[j][k]        = r_rem[j][k] - w_d[j];
                    n_q[j][k][NB-1-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NB; j++) r_v[j] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < NB; j++) r_v[j+1] <= r_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len[0]  <= i_len;
            r_side[0] <= i_side;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= (NUMW'(i_mag[k*MB +: MB]) << (NB - 1))
                             + NUMW'(i_len[LB-1:1]);
                r_q[0][k]   <= '0;
            end
            for (int j = 0; j < NB; j++) begin
                r_len[j+1]  <= r_len[j];
                r_side[j+1] <= r_side[j];
                r_rem[j+1]  <= n_rem[j];
                r_q[j+1]    <= n_q[j];
            end
        end
    end

    assign o_valid = r_v[NB];
    assign o_side  = r_side[NB];
    assign o_quot  = {r_q[NB][2], r_q[NB][1], r_q[NB][0]};
endmodule

[hdl/tfn_back.sv]
// Back end: scaling, length, division, saturation and the result register.
`timescale 1ns / 1ps
module tfn_back #(
    parameter int COORD_BITS = 24,
    parameter int NORMAL_BITS = 16,
    parameter int INDEX_BITS = 16,
    parameter int QW = 160
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [QW-1:0]          i_q_data,
    input  tfn_pkg::t_q_status     i_q_status,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [NORMAL_BITS-1:0] o_normal_x,
    output logic [NORMAL_BITS-1:0] o_normal_y,
    output logic [NORMAL_BITS-1:0] o_normal_z,
    output logic [INDEX_BITS-1:0]  o_out_index_a,
    output logic [INDEX_BITS-1:0]  o_out_index_b,
    output logic [INDEX_BITS-1:0]  o_out_index_c,
    output logic                   o_degenerate
);
    localparam int DW   = ((COORD_BITS > 31) ? 31 : COORD_BITS) + 1;
    localparam int CW   = 2 * DW + 1;
    localparam int MW   = 2 * DW;
    localparam int SW   = $clog2(MW + 1);
    localparam int MB   = tfn_pkg::MAG_BITS;
    localparam int SQB  = tfn_pkg::SQ_BITS;
    localparam int L2B  = tfn_pkg::LEN2_BITS;
    localparam int NB   = NORMAL_BITS;
    localparam int IW   = 3 * INDEX_BITS + 1;
    localparam int S1W  = IW + 3;
    localparam int S2W  = S1W + 3 * MB;
    localparam logic [NB-1:0] NMAX = {1'b0, {(NB-1){1'b1}}};

    logic                        w_en;
    logic                        r_ov;
    logic signed [CW-1:0]        w_cross [3];
    logic [CW-1:0]               w_abs [3];
    logic [MW+MB-1:0]            w_ext [3];
    logic [SW-1:0]               w_len;
    logic [MW-1:0]               w_max01;

    logic [6:1]                  r_v;
    logic [IW-1:0]               r_info [6:1];
    logic [2:0]                  r_neg [6:1];
    logic [MW-1:0]               r_mag1 [3];
    logic [MW-1:0]               r_mag2 [3];
    logic [MW-1:0]               r_max;
    logic [MW-1:0]               r_mag3 [3];
    logic [SW-1:0]               r_sh;
    logic [MB-1:0]               r_m [6:4][3];
    logic [SQB-1:0]              r_sq [3];
    logic [L2B-1:0]              r_len2;

    logic                        w_sq_v, w_dv_v;
    logic [tfn_pkg::ROOT_BITS-1:0] w_root;
    logic [S2W-1:0]              w_sq_side;
    logic [3*NB-1:0]             w_quot;
    logic [S1W-1:0]              w_dv_side;
    logic [NB-1:0]               w_q [3];
    logic [NB-1:0]               w_qs [3];
    logic [NB-1:0]               n_nrm [3];

    assign w_en    = !r_ov || i_pop;
    assign o_q_pop = w_en && !i_q_status.empty;
    assign o_empty = !r_ov;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_cross[k] = $signed(i_q_data[k*CW +: CW]);
            w_abs[k]   = w_cross[k][CW-1] ? (CW'(0) - w_cross[k]) : w_cross[k];
            w_ext[k]   = {r_mag3[k], {MB{1'b0}}} << r_sh;
        end
        w_max01 = (r_mag1[0] > r_mag1[1]) ? r_mag1[0] : r_mag1[1];
        w_len   = '0;
        for (int i = 0; i < MW; i++) begin
            if (r_max[i]) w_len = SW'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[5:1], !i_q_status.empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_info[1] <= i_q_data[3*CW +: IW];
            r_neg[1]  <= {w_cross[2][CW-1], w_cross[1][CW-1], w_cross[0][CW-1]};
            for (int s = 2; s <= 6; s++) begin
                r_info[s] <= r_info[s-1];
                r_neg[s]  <= r_neg[s-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_mag1[k] <= w_abs[k][MW-1:0];
                r_mag3[k] <= r_mag2[k];
                r_m[4][k] <= w_ext[k][MW+MB-1:MW];
                r_m[5][k] <= r_m[4][k];
                r_m[6][k] <= r_m[5][k];
                r_sq[k]   <= r_m[4][k] * r_m[4][k];
            end
            r_mag2 <= r_mag1;
            r_max  <= (w_max01 > r_mag1[2]) ? w_max01 : r_mag1[2];
            r_sh   <= SW'(MW) - w_len;
            r_len2 <= L2B'(r_sq[0]) + L2B'(r_sq[1]) + L2B'(r_sq[2]);
        end
    end

    tfn_sqrt #(.SIDEW(S2W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v[6]),
        .i_n     (r_len2),
        .i_side  ({r_m[6][2], r_m[6][1], r_m[6][0], r_neg[6], r_info[6]}),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    tfn_div #(.NORMAL_BITS(NB), .SIDEW(S1W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_len   (w_root),
        .i_mag   (w_sq_side[S2W-1:S1W]),
        .i_side  (w_sq_side[S1W-1:0]),
        .o_valid (w_dv_v),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k]   = w_quot[k*NB +: NB];
            w_qs[k]  = (w_q[k] > NMAX) ? NMAX : w_q[k];
            n_nrm[k] = w_dv_side[IW + k] ? (NB'(0) - w_qs[k]) : w_qs[k];
            if (w_dv_side[IW-1]) n_nrm[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_normal_x    <= n_nrm[0];
            o_normal_y    <= n_nrm[1];
            o_normal_z    <= n_nrm[2];
            o_out_index_a <= w_dv_side[0 +: INDEX_BITS];
            o_out_index_b <= w_dv_side[INDEX_BITS +: INDEX_BITS];
            o_out_index_c <= w_dv_side[2*INDEX_BITS +: INDEX_BITS];
            o_degenerate  <= w_dv_side[IW-1];
        end
    end

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_degenerate) |->
        (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("degenerate item with a nonzero normal");
endmodule

[hdl/triangle_face_normal.sv]
// Top level of the triangle face normal block.
//
//  channel   direction  handshake     fields
//  triangle  in         push / full   a_*, b_*, c_*, index_a..c
//  normal    out        pop / empty   normal_*, out_index_a..c, degenerate
//
// One triangle is accepted per cycle while full is low; a stalled back end
// pipeline holds the flow. Latency is set mostly by the square root and the
// divider. Reset is synchronous and empties the pipeline and the queue. A held
// result freezes the back end, while the front end keeps filling the
// four-entry queue until it is full.
`timescale 1ns / 1ps
module triangle_face_normal #(
    parameter int COORD_BITS = 24,
    parameter int NORMAL_BITS = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [COORD_BITS-1:0]  i_a_x,
    input  logic [COORD_BITS-1:0]  i_a_y,
    input  logic [COORD_BITS-1:0]  i_a_z,
    input  logic [COORD_BITS-1:0]  i_b_x,
    input  logic [COORD_BITS-1:0]  i_b_y,
    input  logic [COORD_BITS-1:0]  i_b_z,
    input  logic [COORD_BITS-1:0]  i_c_x,
    input  logic [COORD_BITS-1:0]  i_c_y,
    input  logic [COORD_BITS-1:0]  i_c_z,
    input  logic [INDEX_BITS-1:0]  i_index_a,
    input  logic [INDEX_BITS-1:0]  i_index_b,
    input  logic [INDEX_BITS-1:0]  i_index_c,
    output logic                   empty,
    input  logic                   pop,
    output logic [NORMAL_BITS-1:0] o_normal_x,
    output logic [NORMAL_BITS-1:0] o_normal_y,
    output logic [NORMAL_BITS-1:0] o_normal_z,
    output logic [INDEX_BITS-1:0]  o_out_index_a,
    output logic [INDEX_BITS-1:0]  o_out_index_b,
    output logic [INDEX_BITS-1:0]  o_out_index_c,
    output logic                   o_degenerate
);
    localparam int DW = ((COORD_BITS > 31) ? 31 : COORD_BITS) + 1;
    localparam int CW = 2 * DW + 1;
    localparam int QW = 3 * CW + 3 * INDEX_BITS + 1;

    tfn_pkg::t_q_status w_q_status;
    logic               w_q_push, w_q_pop;
    logic [QW-1:0]      w_q_wdata, w_q_rdata;

    tfn_front #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS), .QW(QW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_a_x      (i_a_x),
        .i_a_y      (i_a_y),
        .i_a_z      (i_a_z),
        .i_b_x      (i_b_x),
        .i_b_y      (i_b_y),
        .i_b_z      (i_b_z),
        .i_c_x      (i_c_x),
        .i_c_y      (i_c_y),
        .i_c_z      (i_c_z),
        .i_index_a  (i_index_a),
        .i_index_b  (i_index_b),
        .i_index_c  (i_index_c),
        .i_q_status (w_q_status),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    tfn_queue #(.W(QW)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_data   (w_q_wdata),
        .i_pop    (w_q_pop),
        .o_data   (w_q_rdata),
        .o_status (w_q_status)
    );

    tfn_back #(
        .COORD_BITS(COORD_BITS), .NORMAL_BITS(NORMAL_BITS),
        .INDEX_BITS(INDEX_BITS), .QW(QW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_data      (w_q_rdata),
        .i_q_status    (w_q_status),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z),
        .o_out_index_a (o_out_index_a),
        .o_out_index_b (o_out_index_b),
        .o_out_index_c (o_out_index_c),
        .o_degenerate  (o_degenerate)
    );
endmodule

[dv/triangle_face_normal_tb.sv]
// Self-checking testbench for the triangle face normal block.
`timescale 1ns / 1ps
module triangle_face_normal_tb;

    localparam int CB = 24;
    localparam int NB = 16;
    localparam int IB = 16;
    localparam int NUM_RANDOM = 1200;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic [CB-1:0] crd[9];
        logic [IB-1:0] idx[3];
    } triangle_t;

    typedef struct {
        logic [NB-1:0] nrm[3];
        logic [IB-1:0] idx[3];
        logic          degen;
    } normal_t;

    class normal_board;
        normal_t pending[$];
        int      errors = 0;
        int      checked = 0;
        int      degen_seen = 0;

        function automatic longint unsigned root_floor(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic normal_t unit_normal(triangle_t t);
            normal_t         r;
            longint          p[9];
            longint          u[3];
            longint          w[3];
            longint          cr[3];
            longint unsigned mag[3];
            longint unsigned maxm;
            longint unsigned len2;
            longint unsigned len;
            longint unsigned q;
            bit              neg[3];
            int              l;
            for (int i = 0; i < 9; i++) p[i] = longint'($signed(t.crd[i]));
            for (int i = 0; i < 3; i++) begin
                u[i] = p[3+i] - p[6+i];
                w[i] = p[3+i] - p[i];
                r.idx[i] = t.idx[i];
            end
            cr[0] = u[1] * w[2] - u[2] * w[1];
            cr[1] = u[2] * w[0] - u[0] * w[2];
            cr[2] = u[0] * w[1] - u[1] * w[0];
            maxm = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = cr[i] < 0;
                mag[i] = neg[i] ? longint'(-cr[i]) : longint'(cr[i]);
                if (mag[i] > maxm) maxm = mag[i];
            end
            r.degen = (maxm == 0);
            if (r.degen) begin
                for (int i = 0; i < 3; i++) r.nrm[i] = '0;
                return r;
            end
            l = 0;
            while (maxm != 0) begin
                l++;
                maxm = maxm >> 1;
            end
            len2 = 0;
            for (int i = 0; i < 3; i++) begin
                if (l > 30) mag[i] = mag[i] >> (l - 30);
                else mag[i] = mag[i] << (30 - l);
                len2 += mag[i] * mag[i];
            end
            len = root_floor(len2);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * (64'd1 << (NB - 1)) + (len >> 1)) / len;
                if (q > (64'd1 << (NB - 1)) - 1) q = (64'd1 << (NB - 1)) - 1;
                r.nrm[i] = neg[i] ? NB'(-q) : NB'(q);
            end
            return r;
        endfunction

        function void note_triangle(triangle_t t);
            pending.push_back(unit_normal(t));
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch on normal %0d: %s got %0h expected %0h", checked, what, got,
                     want);
            errors++;
        endtask

        task check_normal(normal_t got);
            normal_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.nrm[i] !== want.nrm[i]) report_mismatch("normal", got.nrm[i],
                                                                want.nrm[i]);
                if (got.idx[i] !== want.idx[i]) report_mismatch("index", got.idx[i],
                                                                want.idx[i]);
            end
            if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
            if (want.degen) degen_seen++;
            checked++;
        endtask
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    logic          empty;
    logic          pop;
    logic [CB-1:0] crd_in[9];
    logic [IB-1:0] idx_in[3];
    logic [NB-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic [IB-1:0] o_out_index_a, o_out_index_b, o_out_index_c;
    logic          o_degenerate;

    normal_board board = new();
    triangle_t   triangles[$];
    int          accepted = 0;
    int          hold_left = 0;
    bit          hold_done = 0;

    triangle_face_normal #(.COORD_BITS(CB), .NORMAL_BITS(NB), .INDEX_BITS(IB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_a_x(crd_in[0]), .i_a_y(crd_in[1]), .i_a_z(crd_in[2]),
        .i_b_x(crd_in[3]), .i_b_y(crd_in[4]), .i_b_z(crd_in[5]),
        .i_c_x(crd_in[6]), .i_c_y(crd_in[7]), .i_c_z(crd_in[8]),
        .i_index_a(idx_in[0]), .i_index_b(idx_in[1]), .i_index_c(idx_in[2]),
        .empty(empty), .pop(pop),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_out_index_a(o_out_index_a), .o_out_index_b(o_out_index_b),
        .o_out_index_c(o_out_index_c), .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, int ia, int ib, int ic);
        triangle_t t;
        t.crd[0] = CB'(ax); t.crd[1] = CB'(ay); t.crd[2] = CB'(az);
        t.crd[3] = CB'(bx); t.crd[4] = CB'(by); t.crd[5] = CB'(bz);
        t.crd[6] = CB'(cx); t.crd[7] = CB'(cy); t.crd[8] = CB'(cz);
        t.idx[0] = IB'(ia); t.idx[1] = IB'(ib); t.idx[2] = IB'(ic);
        return t;
    endfunction

    task automatic build_triangles();
        int        mx;
        int        mn;
        triangle_t t;
        mx = (1 << (CB - 1)) - 1;
        mn = -(1 << (CB - 1));
        triangles.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        triangles.push_back(make_tri(5, 7, 9, 5, 7, 9, 1, 2, 3, 65535, 65535, 65535));
        triangles.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 2, 3));
        triangles.push_back(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 1, 2));
        triangles.push_back(make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096, 3, 4, 5));
        triangles.push_back(make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0, 6, 7, 8));
        triangles.push_back(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 9, 10, 11));
        triangles.push_back(make_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn, 0, 65535, 0));
        triangles.push_back(make_tri(mx, mn, mn, mn, mx, mn, mn, mn, mx, 65535, 0, 65535));
        triangles.push_back(make_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn, 1, 0, 0));
        triangles.push_back(make_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx, 0, 1, 0));
        triangles.push_back(make_tri(mn, 0, mx, mx, mn, 0, 0, mx, mn, 0, 0, 1));
        triangles.push_back(make_tri(mn, mn, mn, mn, mn, mn, mx, mx, mx, 2, 2, 2));
        triangles.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1, 100, 200, 300));
        triangles.push_back(make_tri(-1, -1, 0, 1, -1, 0, 0, 1, 1, 7, 7, 7));
        triangles.push_back(make_tri(3, 0, 0, 0, 4, 0, 0, 0, 0, 40000, 30000, 20000));
        triangles.push_back(make_tri(mx, mx, mx, mx - 1, mx, mx, mx, mx - 1, mx, 1, 2, 1));
        for (int n = 0; n < NUM_RANDOM; n++) begin
            int kind;
            int base;
            kind = $urandom_range(99);
            for (int i = 0; i < 3; i++) t.idx[i] = IB'($urandom);
            if (kind < 70) begin
                for (int i = 0; i < 9; i++) t.crd[i] = CB'($urandom);
            end else if (kind < 92) begin
                for (int i = 0; i < 3; i++) begin
                    base = $urandom_range(mx - 64) - $urandom_range(mx - 64);
                    t.crd[i] = CB'(base + int'($urandom_range(128)) - 64);
                    t.crd[3+i] = CB'(base + int'($urandom_range(128)) - 64);
                    t.crd[6+i] = CB'(base + int'($urandom_range(128)) - 64);
                end
            end else begin
                for (int i = 0; i < 6; i++) t.crd[i] = CB'($urandom);
                for (int i = 0; i < 3; i++) t.crd[6+i] = t.crd[3 * $urandom_range(1) + i];
            end
            triangles.push_back(t);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                board.note_triangle(triangles.pop_front());
                accepted++;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (triangles.size() != 0 &&
                         ((accepted > 600 && accepted < 850) || $urandom_range(99) >= 38)) begin
                push <= 1'b1;
                crd_in <= triangles[0].crd;
                idx_in <= triangles[0].idx;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        normal_t got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.nrm[0] = o_normal_x; got.nrm[1] = o_normal_y; got.nrm[2] = o_normal_z;
                got.idx[0] = o_out_index_a; got.idx[1] = o_out_index_b;
                got.idx[2] = o_out_index_c; got.degen = o_degenerate;
                board.check_normal(got);
            end
            if (!hold_done && accepted >= 300) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= (accepted > 600 && accepted < 850) || $urandom_range(99) >= 38;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        for (int i = 0; i < 9; i++) crd_in[i] <= '0;
        for (int i = 0; i < 3; i++) idx_in[i] <= '0;
        build_triangles();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (triangles.size() == 0 && !push);
        wait (board.pending.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Checked %0d triangles, %0d of them degenerate, through a long output stall.",
                 board.checked, board.degen_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS triangle_face_normal");
        end else begin
            $display("FAIL triangle_face_normal");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("FAIL triangle_face_normal");
        $finish;
    end

endmodule
